### src/first_fit_extent_allocator_unit_assert.svh
// Assertion macros for the extent allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define FFEA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FFEA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ffea_pkg.sv
// Shared types and constants of the extent allocator.
// No dependencies; used by every module of the block.
package ffea_pkg;

    localparam int ADDR_WIDTH      = 16;
    localparam int MAX_EXTENTS_DEF = 16;

    localparam logic [ADDR_WIDTH-1:0] ADDR_LIMIT = '1;
    localparam logic [ADDR_WIDTH-1:0] POOL_RESET = ADDR_WIDTH'(100);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] start;
        logic [ADDR_WIDTH-1:0] len;
    } entry_t;

    typedef struct packed {
        logic                  kind;
        logic [ADDR_WIDTH-1:0] block_size;
        logic [ADDR_WIDTH-1:0] block_start;
    } request_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] granted_start;
        status_t               status;
    } result_t;

endpackage

### src/first_fit_extent_allocator_unit.sv
// Top level of the first-fit extent allocator: stream ports, result register.
// Depends on ffea_pkg, ffea_seq and the assertion macro header.
//
// Keeps an address-ordered table of free extents in a small memory with one read
// port and one write port, walked by a sequencer around one shared adder and
// subtractor. An allocate takes the first extent that fits, or fails if none does;
// when that extent is used up, the entries above it move down. A free that needs a
// new entry moves the entries above it up, and one that joins both neighbours closes
// the gap; a free of zero units or at the top address changes nothing. A new item is
// taken in the cycle after the previous result enters the output register, which
// holds it until taken. After reset the block sets up the table in its init state.
module first_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // block_size[15:0], block_start[31:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // granted_start[15:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

`include "first_fit_extent_allocator_unit_assert.svh"

    localparam int AW = ffea_pkg::ADDR_WIDTH;
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    ffea_pkg::request_t req;
    ffea_pkg::result_t  res;
    logic               seq_idle;
    logic               res_valid;
    logic               out_free;
    logic [CW-1:0]      count;

    logic          m_tvalid_reg;
    logic [AW-1:0] granted_reg;
    logic [1:0]    status_reg;

    assign req.kind        = s_tuser;
    assign req.block_size  = s_tdata[AW-1:0];
    assign req.block_start = s_tdata[2*AW-1:AW];

    assign s_tready = seq_idle;
    assign out_free = !m_tvalid_reg || m_tready;

    ffea_seq #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && seq_idle),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_free  (out_free),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res       (res),
        .count     (count)
    );

    // hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            granted_reg <= res.granted_start;
            status_reg  <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

    `FFEA_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(MAX_EXTENTS), "extent count over table depth")
    `FFEA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `FFEA_ASSERT_IMP(a_result_slot_free, res_valid, !m_tvalid_reg || m_tready, "result overwrites pending item")
    `FFEA_ASSERT_NXT(a_cfg_single_extent, cfg_we && cfg_wdata != '0, count == CW'(1), "pool write did not reset table")

endmodule

### src/ffea_table.sv
// Free extent table: one write port, one registered read port.
// Depends on ffea_pkg for the entry type.
module ffea_table #(
    parameter int DEPTH = ffea_pkg::MAX_EXTENTS_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  ffea_pkg::entry_t     wdata,
    input  logic [IW-1:0]        raddr,
    output ffea_pkg::entry_t     rdata
);

    ffea_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/ffea_alu.sv
// Adder and subtractor shared by the steps of the sequencer.
// Depends on ffea_pkg for the address width.
module ffea_alu (
    input  logic [ffea_pkg::ADDR_WIDTH-1:0] add_a,
    input  logic [ffea_pkg::ADDR_WIDTH-1:0] add_b,
    input  logic [ffea_pkg::ADDR_WIDTH-1:0] sub_a,
    input  logic [ffea_pkg::ADDR_WIDTH-1:0] sub_b,
    output logic [ffea_pkg::ADDR_WIDTH:0]   sum,
    output logic [ffea_pkg::ADDR_WIDTH-1:0] diff,
    output logic                            borrow
);

    logic [ffea_pkg::ADDR_WIDTH:0] sub_full;

    assign sum      = {1'b0, add_a} + {1'b0, add_b};
    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign diff     = sub_full[ffea_pkg::ADDR_WIDTH-1:0];
    // borrow set means sub_a < sub_b
    assign borrow   = sub_full[ffea_pkg::ADDR_WIDTH];

endmodule

### src/ffea_seq.sv
// Request sequencer: walks the extent table, merges, inserts and shifts entries.
// Depends on ffea_pkg, ffea_table and ffea_alu.
module ffea_seq #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF,
    parameter int IW          = $clog2(MAX_EXTENTS),
    parameter int CW          = $clog2(MAX_EXTENTS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  ffea_pkg::request_t              req,
    input  logic                            cfg_we,
    input  logic [ffea_pkg::ADDR_WIDTH-1:0] cfg_wdata,
    input  logic                            out_free,
    output logic                            idle,
    output logic                            res_valid,
    output ffea_pkg::result_t               res,
    output logic [CW-1:0]                   count
);

    localparam int AW = ffea_pkg::ADDR_WIDTH;

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_PREP1  = 11'b000_0000_0100,
        S_PREP2  = 11'b000_0000_1000,
        S_SCAN   = 11'b000_0001_0000,
        S_DECIDE = 11'b000_0010_0000,
        S_MERGE1 = 11'b000_0100_0000,
        S_MERGE2 = 11'b000_1000_0000,
        S_SHUP   = 11'b001_0000_0000,
        S_SHDN   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic          kind_reg, kind_next;
    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] prev_start_reg, prev_start_next;
    logic [AW-1:0] prev_len_reg, prev_len_next;
    logic          has_prev_reg, has_prev_next;
    logic [AW-1:0] cur_start_reg, cur_start_next;
    logic [AW-1:0] cur_len_reg, cur_len_next;
    logic          has_next_reg, has_next_next;
    logic          join_low_reg, join_low_next;
    logic          join_high_reg, join_high_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] granted_reg, granted_next;
    ffea_pkg::status_t status_reg, status_next;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    ffea_pkg::entry_t mem_wdata;
    logic [IW-1:0]    mem_raddr;
    ffea_pkg::entry_t mem_rdata;

    logic [AW-1:0] add_a, add_b, sub_a, sub_b;
    logic [AW:0]   alu_sum;
    logic [AW-1:0] alu_diff;
    logic          alu_borrow;

    logic [CW-1:0] idx_inc, idx_dec, j_inc, j_inc2, j_dec, j_dec2, cnt_dec;

    ffea_table #(
        .DEPTH (MAX_EXTENTS),
        .IW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffea_alu u_alu (
        .add_a  (add_a),
        .add_b  (add_b),
        .sub_a  (sub_a),
        .sub_b  (sub_b),
        .sum    (alu_sum),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;
    assign j_inc   = j_reg + 1'b1;
    assign j_inc2  = j_reg + CW'(2);
    assign j_dec   = j_reg - 1'b1;
    assign j_dec2  = j_reg - CW'(2);
    assign cnt_dec = cnt_reg - 1'b1;

    assign idle            = (state_reg == S_IDLE);
    assign count           = cnt_reg;
    assign res.granted_start = granted_reg;
    assign res.status      = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        kind_next       = kind_reg;
        size_next       = size_reg;
        base_next       = base_reg;
        end_next        = end_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        has_prev_next   = has_prev_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        has_next_next   = has_next_reg;
        join_low_next   = join_low_reg;
        join_high_next  = join_high_reg;
        acc_next        = acc_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        add_a           = '0;
        add_b           = '0;
        sub_a           = '0;
        sub_b           = '0;
        res_valid       = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                mem_we          = 1'b1;
                mem_wdata.start = '0;
                mem_wdata.len   = ffea_pkg::POOL_RESET;
                cnt_next        = CW'(1);
                state_next      = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = req.kind;
                    size_next     = req.block_size;
                    base_next     = req.block_start;
                    idx_next      = '0;
                    has_prev_next = 1'b0;
                    granted_next  = '0;
                    status_next   = ffea_pkg::ST_OK;
                    if (req.kind == ffea_pkg::KIND_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.block_size == '0 || req.block_start == ffea_pkg::ADDR_LIMIT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PREP1;
                    end
                end
            end

            S_PREP1:
            begin
                // clip the freed run at the top of the address space
                add_a      = base_reg;
                add_b      = size_reg;
                end_next   = alu_sum[AW] ? ffea_pkg::ADDR_LIMIT : alu_sum[AW-1:0];
                state_next = S_PREP2;
            end

            S_PREP2:
            begin
                sub_a      = end_reg;
                sub_b      = base_reg;
                size_next  = alu_diff;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                mem_raddr = idx_inc[IW-1:0];
                if (kind_reg == ffea_pkg::KIND_ALLOC)
                begin
                    add_a = mem_rdata.start;
                    add_b = size_reg;
                    sub_a = mem_rdata.len;
                    sub_b = size_reg;
                    if (idx_reg >= cnt_reg)
                    begin
                        status_next = ffea_pkg::ST_NO_SPACE;
                        state_next  = S_DONE;
                    end
                    else if (!alu_borrow)
                    begin
                        granted_next = mem_rdata.start;
                        if (alu_diff == '0)
                        begin
                            // extent used up: close the gap
                            j_next     = idx_reg;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = idx_reg[IW-1:0];
                            mem_wdata.start = alu_sum[AW-1:0];
                            mem_wdata.len   = alu_diff;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    sub_a = mem_rdata.start;
                    sub_b = base_reg;
                    if (idx_reg < cnt_reg && alu_borrow)
                    begin
                        prev_start_next = mem_rdata.start;
                        prev_len_next   = mem_rdata.len;
                        has_prev_next   = 1'b1;
                        idx_next        = idx_inc;
                    end
                    else
                    begin
                        cur_start_next = mem_rdata.start;
                        cur_len_next   = mem_rdata.len;
                        has_next_next  = (idx_reg < cnt_reg);
                        state_next     = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                add_a          = prev_start_reg;
                add_b          = prev_len_reg;
                join_low_next  = has_prev_reg && (alu_sum == {1'b0, base_reg});
                join_high_next = has_next_reg && (cur_start_reg == end_reg);
                state_next     = S_MERGE1;
            end

            S_MERGE1:
            begin
                if (join_low_reg && join_high_reg)
                begin
                    add_a      = prev_len_reg;
                    add_b      = size_reg;
                    acc_next   = alu_sum[AW-1:0];
                    state_next = S_MERGE2;
                end
                else if (join_low_reg)
                begin
                    add_a           = prev_len_reg;
                    add_b           = size_reg;
                    mem_we          = 1'b1;
                    mem_waddr       = idx_dec[IW-1:0];
                    mem_wdata.start = prev_start_reg;
                    mem_wdata.len   = alu_sum[AW-1:0];
                    state_next      = S_DONE;
                end
                else if (join_high_reg)
                begin
                    add_a           = cur_len_reg;
                    add_b           = size_reg;
                    mem_we          = 1'b1;
                    mem_waddr       = idx_reg[IW-1:0];
                    mem_wdata.start = base_reg;
                    mem_wdata.len   = alu_sum[AW-1:0];
                    state_next      = S_DONE;
                end
                else if (cnt_reg == CW'(MAX_EXTENTS))
                begin
                    status_next = ffea_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_raddr  = cnt_dec[IW-1:0];
                    j_next     = cnt_reg;
                    state_next = S_SHUP;
                end
            end

            S_MERGE2:
            begin
                add_a           = acc_reg;
                add_b           = cur_len_reg;
                mem_we          = 1'b1;
                mem_waddr       = idx_dec[IW-1:0];
                mem_wdata.start = prev_start_reg;
                mem_wdata.len   = alu_sum[AW-1:0];
                mem_raddr       = idx_inc[IW-1:0];
                j_next          = idx_reg;
                state_next      = S_SHDN;
            end

            S_SHUP:
            begin
                // rdata holds entry j-1; move it up to j
                mem_raddr = j_dec2[IW-1:0];
                mem_we    = 1'b1;
                mem_waddr = j_reg[IW-1:0];
                if (j_reg > idx_reg)
                begin
                    mem_wdata = mem_rdata;
                    j_next    = j_dec;
                end
                else
                begin
                    mem_wdata.start = base_reg;
                    mem_wdata.len   = size_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    state_next      = S_DONE;
                end
            end

            S_SHDN:
            begin
                // rdata holds entry j+1; move it down to j
                mem_raddr = j_inc2[IW-1:0];
                if (j_inc < cnt_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg[IW-1:0];
                    mem_wdata = mem_rdata;
                    j_next    = j_inc;
                end
                else
                begin
                    cnt_next   = cnt_dec;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pool write reinitializes the table; the user must write it only while idle, the block does not enforce this
        if (cfg_we)
        begin
            mem_we          = 1'b1;
            mem_waddr       = '0;
            mem_wdata.start = '0;
            mem_wdata.len   = cfg_wdata;
            cnt_next        = (cfg_wdata != '0) ? CW'(1) : '0;
            if (state_reg == S_INIT)
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        kind_reg       <= kind_next;
        size_reg       <= size_next;
        base_reg       <= base_next;
        end_reg        <= end_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        has_prev_reg   <= has_prev_next;
        cur_start_reg  <= cur_start_next;
        cur_len_reg    <= cur_len_next;
        has_next_reg   <= has_next_next;
        join_low_reg   <= join_low_next;
        join_high_reg  <= join_high_next;
        acc_reg        <= acc_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

endmodule

### tb/extent_allocator_checker.sv
`timescale 1ns / 1ps
// Result checker for the first-fit extent allocator: keeps its own free-extent
// table, predicts each result item and compares it with the master side.
// Depends on ffea_pkg; instantiated by testbench next to the block.
module extent_allocator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    localparam int AW          = ffea_pkg::ADDR_WIDTH;
    localparam int TABLE_DEPTH = ffea_pkg::MAX_EXTENTS_DEF;
    localparam int ADDR_TOP    = (1 << AW) - 1;

    logic [AW-1:0]     free_base [TABLE_DEPTH];
    logic [AW-1:0]     free_len  [TABLE_DEPTH];
    int                free_count;
    ffea_pkg::result_t expected_results [$];

    function automatic void reload_pool(input logic [AW-1:0] pool);
        free_base[0] = '0;
        free_len[0]  = pool;
        free_count   = (pool == 0) ? 0 : 1;
    endfunction

    function automatic void drop_extent(input int pos);
        for (int i = pos; i + 1 < free_count; i++)
        begin
            free_base[i] = free_base[i+1];
            free_len[i]  = free_len[i+1];
        end
        free_count--;
    endfunction

    function automatic ffea_pkg::result_t predict_request(input logic kind,
                                                          input logic [AW-1:0] size,
                                                          input logic [AW-1:0] base);
        ffea_pkg::result_t r;
        int      hit;
        int      pos;
        int      len;
        int      end_addr;
        bit      join_low;
        bit      join_high;
        r.granted_start = '0;
        r.status        = ffea_pkg::ST_OK;
        if (kind == ffea_pkg::KIND_ALLOC)
        begin
            hit = -1;
            for (int i = 0; i < free_count; i++)
                if (hit < 0 && free_len[i] >= size)
                    hit = i;
            if (hit < 0)
            begin
                r.status = ffea_pkg::ST_NO_SPACE;
                return r;
            end
            // carve from the low end of the first extent that fits
            r.granted_start = free_base[hit];
            free_base[hit]  = free_base[hit] + size;
            free_len[hit]   = free_len[hit] - size;
            if (free_len[hit] == 0)
                drop_extent(hit);
            return r;
        end
        if (size == 0 || int'(base) >= ADDR_TOP)
            return r;
        len = int'(size);
        if (len > ADDR_TOP - int'(base))
            len = ADDR_TOP - int'(base);
        end_addr = int'(base) + len;
        pos = 0;
        while (pos < free_count && free_base[pos] < base)
            pos++;
        join_low = 1'b0;
        if (pos > 0)
            join_low = (int'(free_base[pos-1]) + int'(free_len[pos-1]) == int'(base));
        join_high = 1'b0;
        if (pos < free_count)
            join_high = (int'(free_base[pos]) == end_addr);
        if (join_low && join_high)
        begin
            free_len[pos-1] = AW'(int'(free_len[pos-1]) + len + int'(free_len[pos]));
            drop_extent(pos);
        end
        else if (join_low)
        begin
            free_len[pos-1] = AW'(int'(free_len[pos-1]) + len);
        end
        else if (join_high)
        begin
            free_base[pos] = base;
            free_len[pos]  = AW'(int'(free_len[pos]) + len);
        end
        else if (free_count >= TABLE_DEPTH)
        begin
            r.status = ffea_pkg::ST_FULL;
        end
        else
        begin
            for (int i = free_count; i > pos; i--)
            begin
                free_base[i] = free_base[i-1];
                free_len[i]  = free_len[i-1];
            end
            free_base[pos] = base;
            free_len[pos]  = AW'(len);
            free_count++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        ffea_pkg::result_t want;
        if (!rst_n)
        begin
            reload_pool(ffea_pkg::POOL_RESET);
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                reload_pool(cfg_wdata);
            // push before pop so an item and its result in one cycle stay ordered
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_request(s_tuser, s_tdata[15:0],
                                                           s_tdata[31:16]));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result item with none expected: start %0d status %0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.granted_start)
                    begin
                        fail_count++;
                        $display("%0t: granted_start mismatch: expected %0d, got %0d",
                                 $time, want.granted_start, m_tdata);
                    end
                    if (m_tuser !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                    end
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the extent allocator testbench: clock, reset, request and pool-size
// stimulus, result back-pressure and the verdict.
// Depends on ffea_pkg, first_fit_extent_allocator_unit and extent_allocator_checker.
module testbench;

    localparam int ITEM_GOAL     = 1950;
    localparam int SETTLE_CYCLES = 2 * ffea_pkg::MAX_EXTENTS_DEF + 16;
    localparam int HOLD_CYCLES   = 400;

    logic        clk       = 1'b0;
    logic        rst_n;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = ffea_pkg::KIND_ALLOC;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    first_fit_extent_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    extent_allocator_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("first_fit_extent_allocator_unit regression: fail");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_request(input logic kind, input logic [15:0] size,
                                input logic [15:0] base);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {base, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_noise();
        logic        kind;
        logic [15:0] size;
        kind = 1'($urandom_range(0, 1));
        size = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 64));
        send_request(kind, size, 16'($urandom_range(0, 65535)));
    endtask

    // write the pool size only once the block has drained
    task automatic load_pool(input logic [15:0] size);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        // reset pool of 100 units
        send_request(ffea_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);
        send_request(ffea_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
        send_request(ffea_pkg::KIND_ALLOC, 16'd100, 16'd0);
        send_request(ffea_pkg::KIND_ALLOC, 16'd0, 16'd0);
        send_request(ffea_pkg::KIND_FREE, 16'hFFFF, 16'hFFFE);
        send_request(ffea_pkg::KIND_FREE, 16'd0, 16'd40);
        send_request(ffea_pkg::KIND_FREE, 16'd5, 16'hFFFF);
        send_request(ffea_pkg::KIND_FREE, 16'd10, 16'd10);
        send_request(ffea_pkg::KIND_FREE, 16'd10, 16'd30);
        send_request(ffea_pkg::KIND_FREE, 16'd10, 16'd20);
        send_request(ffea_pkg::KIND_FREE, 16'd5, 16'd10);
        // fill the table with single-unit extents, then overflow it
        for (int i = 0; i < 13; i++)
            send_request(ffea_pkg::KIND_FREE, 16'd1, 16'(100 + 2 * i));
        send_request(ffea_pkg::KIND_FREE, 16'd1, 16'd200);
        send_request(ffea_pkg::KIND_FREE, 16'd1, 16'd101);
        send_request(ffea_pkg::KIND_ALLOC, 16'd2, 16'd0);
        load_pool(16'hFFFF);
        send_request(ffea_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
        send_request(ffea_pkg::KIND_FREE, 16'hFFFF, 16'd0);
        send_request(ffea_pkg::KIND_ALLOC, 16'd1, 16'd0);
    endtask

    // fresh pool, a run of allocations, then free the granted blocks in random order
    task automatic run_episode(input bit squeeze);
        int unsigned pool;
        int unsigned limit;
        int unsigned cursor;
        int unsigned size;
        int unsigned pick;
        int unsigned tmp;
        int          j;
        int unsigned blk_base [$];
        int unsigned blk_size [$];
        pick = $urandom_range(0, 19);
        if (pick == 0)
            pool = 0;
        else if (pick == 1)
            pool = 1;
        else if (pick == 2)
            pool = 65535;
        else if (pick < 5)
            pool = $urandom_range(0, 65535);
        else
            pool = $urandom_range(16, 1500);
        load_pool(16'(pool));
        if (squeeze)
            hold_request = HOLD_CYCLES;
        limit  = (pool < 16) ? 1 : pool / 8;
        cursor = 0;
        repeat ($urandom_range(4, 40))
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                size = 0;
            else if (pick == 1)
                size = $urandom_range(0, 65535);
            else
                size = $urandom_range(1, limit);
            send_request(ffea_pkg::KIND_ALLOC, 16'(size), 16'($urandom_range(0, 65535)));
            // a fresh table hands out consecutive addresses until it runs dry
            if (size != 0 && size <= pool - cursor)
            begin
                blk_base.push_back(cursor);
                blk_size.push_back(size);
                cursor += size;
            end
        end
        for (int i = blk_base.size() - 1; i > 0; i--)
        begin
            j           = $urandom_range(0, i);
            tmp         = blk_base[i];
            blk_base[i] = blk_base[j];
            blk_base[j] = tmp;
            tmp         = blk_size[i];
            blk_size[i] = blk_size[j];
            blk_size[j] = tmp;
        end
        foreach (blk_base[i])
        begin
            if ($urandom_range(0, 5) == 0)
                send_noise();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_request(ffea_pkg::KIND_FREE, 16'(blk_size[i]), 16'(blk_base[i] + 1));
            else if (pick == 1)
                send_request(ffea_pkg::KIND_FREE, 16'(2 * blk_size[i]), 16'(blk_base[i]));
            else
                send_request(ffea_pkg::KIND_FREE, 16'(blk_size[i]), 16'(blk_base[i]));
        end
    endtask

    initial
    begin : stimulus
        int ep;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        ep = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (ep % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 62;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            run_episode(ep == 4);
            ep++;
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("first_fit_extent_allocator_unit regression: pass");
        else
            $display("first_fit_extent_allocator_unit regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/ffea_pkg.sv
src/ffea_table.sv
src/ffea_alu.sv
src/ffea_seq.sv
src/first_fit_extent_allocator_unit.sv
tb/extent_allocator_checker.sv
tb/testbench.sv
